[hw/rtl/rlp_pkg.sv]
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared types and constants of the relocation list patcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rlp_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RELOC = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] LONG_FLAG = 8'h80;
  localparam logic [7:0] LOW7_MASK = 8'h7F;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_LONG3,
    PH_LONG2,
    PH_LONG1,
    PH_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_WRITE,
    K_READ,
    K_PATCH
  } kind_t;

  typedef struct packed {
    logic        done;
    logic        list_end;
    logic        out_of_range;
    logic [31:0] pos;
    logic [31:0] pos_next;
  } dec_t;

endpackage

`default_nettype wire

[hw/rtl/relocation_list_patcher_top.sv]
// ----------------------------------------------------------------------------
// relocation_list_patcher_top
// Segment store with compressed relocation list decoding and word patching.
// ----------------------------------------------------------------------------
// Input items arrive on item_valid/item_ready and carry a write, a read or
// one relocation byte; each gives exactly one result on result_valid/
// result_ready. The segment sits in two banks, even and odd halfwords, so a
// patch reads both halves of its word at acceptance and writes both back as
// it leaves the read-modify-write stage. One item can be accepted in every
// cycle unless the receiver stalls; a write back that meets the next item's
// read of the same entry is forwarded. The bank read ports hold while the
// stage after them waits, so a stalled receiver stops acceptance only once
// the output register and that stage are both full. Reset clears the decoder,
// the cursor, the delta and the handshake state; the segment holds no defined
// contents until written. cfg_write_en loads reloc_delta at once; the user
// must use it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module relocation_list_patcher_top #(
  parameter int MEM_HALFWORDS = 32768
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic signed [31:0] cfg_write_data,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic [14:0]        halfword_index,
  input  wire logic [15:0]        halfword_value,
  input  wire logic [7:0]         reloc_byte,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [15:0]             read_value,
  output logic                    patch_applied,
  output logic [14:0]             patch_index,
  output logic                    list_end,
  output logic                    out_of_range
);

  localparam int BANK_DEPTH = (MEM_HALFWORDS + 1) / 2;
  localparam int BAW        = $clog2(BANK_DEPTH);

  logic signed [31:0] reloc_delta;

  logic               accept;
  logic               s1_adv;
  rlp_pkg::dec_t      dec;
  logic [31:0]        idx_ext;
  logic               idx_ok;
  logic [BAW-1:0]     rd_addr_even, rd_addr_odd;
  rlp_pkg::kind_t     kind_in;
  logic               bank_in;

  logic               s1_valid;
  rlp_pkg::kind_t     s1_kind;
  logic               s1_bank;
  logic [BAW-1:0]     s1_addr_even, s1_addr_odd;
  logic [15:0]        s1_wdata;
  logic               s1_list_end;
  logic               s1_oor;
  logic [14:0]        s1_patch_index;

  logic               fwd_even, fwd_odd;
  logic [15:0]        fwd_even_data, fwd_odd_data;

  logic [15:0]        rdata_even, rdata_odd;
  logic [15:0]        hw_even, hw_odd;
  logic [31:0]        word;
  logic               we_even, we_odd;
  logic [15:0]        wdata_even, wdata_odd;
  logic [15:0]        rd_value;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reloc_delta <= 32'sd0;
    end else if (cfg_write_en) begin
      reloc_delta <= cfg_write_data;
    end
  end

  rlp_decoder #(
    .MEM_HALFWORDS(MEM_HALFWORDS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .step      (accept && (opcode == rlp_pkg::OP_RELOC)),
    .reloc_byte(reloc_byte),
    .dec       (dec)
  );

  assign idx_ext = {17'd0, halfword_index};
  assign idx_ok  = idx_ext < 32'(MEM_HALFWORDS);

  always_comb begin
    rd_addr_even = idx_ext[BAW:1];
    rd_addr_odd  = idx_ext[BAW:1];
    bank_in      = halfword_index[0];
    unique case (opcode)
      rlp_pkg::OP_WRITE: kind_in = idx_ok ? rlp_pkg::K_WRITE : rlp_pkg::K_NONE;
      rlp_pkg::OP_READ:  kind_in = idx_ok ? rlp_pkg::K_READ : rlp_pkg::K_NONE;
      rlp_pkg::OP_RELOC: begin
        kind_in      = (dec.done && !dec.out_of_range) ? rlp_pkg::K_PATCH : rlp_pkg::K_NONE;
        rd_addr_even = dec.pos_next[BAW:1];
        rd_addr_odd  = dec.pos[BAW:1];
        bank_in      = dec.pos[0];
      end
      default: kind_in = rlp_pkg::K_NONE;
    endcase
  end

  // read-modify-write stage
  always_comb begin
    hw_even    = fwd_even ? fwd_even_data : rdata_even;
    hw_odd     = fwd_odd ? fwd_odd_data : rdata_odd;
    word       = (s1_bank ? {hw_odd, hw_even} : {hw_even, hw_odd}) + $unsigned(reloc_delta);
    we_even    = 1'b0;
    we_odd     = 1'b0;
    wdata_even = s1_wdata;
    wdata_odd  = s1_wdata;
    rd_value   = 16'd0;
    case (s1_kind)
      rlp_pkg::K_WRITE: begin
        we_even = s1_adv && !s1_bank;
        we_odd  = s1_adv && s1_bank;
      end
      rlp_pkg::K_READ: begin
        rd_value = s1_bank ? hw_odd : hw_even;
      end
      rlp_pkg::K_PATCH: begin
        we_even    = s1_adv;
        we_odd     = s1_adv;
        wdata_even = s1_bank ? word[15:0] : word[31:16];
        wdata_odd  = s1_bank ? word[31:16] : word[15:0];
      end
      default: begin
        rd_value = 16'd0;
      end
    endcase
  end

  rlp_ram #(
    .WIDTH(16),
    .DEPTH(BANK_DEPTH)
  ) u_bank_even (
    .clk  (clk),
    .we   (we_even),
    .waddr(s1_addr_even),
    .wdata(wdata_even),
    .re   (accept),
    .raddr(rd_addr_even),
    .rdata(rdata_even)
  );

  rlp_ram #(
    .WIDTH(16),
    .DEPTH(BANK_DEPTH)
  ) u_bank_odd (
    .clk  (clk),
    .we   (we_odd),
    .waddr(s1_addr_odd),
    .wdata(wdata_odd),
    .re   (accept),
    .raddr(rd_addr_odd),
    .rdata(rdata_odd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind        <= kind_in;
      s1_bank        <= bank_in;
      s1_addr_even   <= rd_addr_even;
      s1_addr_odd    <= rd_addr_odd;
      s1_wdata       <= halfword_value;
      s1_list_end    <= (opcode == rlp_pkg::OP_RELOC) && dec.list_end;
      s1_oor         <= (opcode == rlp_pkg::OP_RELOC) && dec.out_of_range;
      s1_patch_index <= ((opcode == rlp_pkg::OP_RELOC) && dec.done) ? dec.pos[14:0] : 15'd0;
      fwd_even       <= we_even && (rd_addr_even == s1_addr_even);
      fwd_odd        <= we_odd && (rd_addr_odd == s1_addr_odd);
      fwd_even_data  <= wdata_even;
      fwd_odd_data   <= wdata_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_value    <= rd_value;
      patch_applied <= (s1_kind == rlp_pkg::K_PATCH);
      patch_index   <= s1_patch_index;
      list_end      <= s1_list_end;
      out_of_range  <= s1_oor;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rlp_ram.sv]
// ----------------------------------------------------------------------------
// rlp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rlp_decoder.sv]
// ----------------------------------------------------------------------------
// rlp_decoder
// Relocation byte decoder: distance assembly and cursor advance.
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_decoder #(
  parameter int MEM_HALFWORDS = 32768
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   reloc_byte,
  output rlp_pkg::dec_t     dec
);

  rlp_pkg::phase_t phase, phase_next;
  logic [31:0] accum, accum_next;
  logic [31:0] cursor, cursor_next;
  logic [31:0] distance;
  logic [31:0] pos;
  logic [32:0] pos_plus;
  logic        done;
  logic        list_end;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      rlp_pkg::PH_IDLE: begin
        if (reloc_byte == 8'd0) begin
          phase_next = rlp_pkg::PH_ZERO;
        end else if ((reloc_byte & rlp_pkg::LONG_FLAG) != 8'd0) begin
          phase_next = rlp_pkg::PH_HIGH;
        end
      end
      rlp_pkg::PH_ZERO: begin
        phase_next = (reloc_byte == 8'd0) ? rlp_pkg::PH_IDLE : rlp_pkg::PH_LONG3;
      end
      rlp_pkg::PH_LONG3: phase_next = rlp_pkg::PH_LONG2;
      rlp_pkg::PH_LONG2: phase_next = rlp_pkg::PH_LONG1;
      rlp_pkg::PH_LONG1: phase_next = rlp_pkg::PH_IDLE;
      rlp_pkg::PH_HIGH:  phase_next = rlp_pkg::PH_IDLE;
      default:           phase_next = rlp_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    accum_next = accum;
    distance   = accum;
    done       = 1'b0;
    list_end   = 1'b0;
    unique case (phase)
      rlp_pkg::PH_IDLE: begin
        if (reloc_byte != 8'd0) begin
          if ((reloc_byte & rlp_pkg::LONG_FLAG) != 8'd0) begin
            accum_next = {16'd0, reloc_byte & rlp_pkg::LOW7_MASK, 8'd0};
          end else begin
            distance = {24'd0, reloc_byte};
            done     = 1'b1;
          end
        end
      end
      rlp_pkg::PH_ZERO: begin
        if (reloc_byte == 8'd0) begin
          accum_next = 32'd0;
          list_end   = 1'b1;
        end else begin
          accum_next = {24'd0, reloc_byte};
        end
      end
      rlp_pkg::PH_LONG3, rlp_pkg::PH_LONG2: begin
        accum_next = {accum[23:0], reloc_byte};
      end
      rlp_pkg::PH_LONG1: begin
        accum_next = {accum[23:0], reloc_byte};
        distance   = accum_next;
        done       = 1'b1;
      end
      rlp_pkg::PH_HIGH: begin
        accum_next = accum | {24'd0, reloc_byte};
        distance   = accum_next;
        done       = 1'b1;
      end
      default: begin
        accum_next = accum;
      end
    endcase
  end

  assign pos      = cursor + distance;
  assign pos_plus = {1'b0, pos} + 33'd1;

  always_comb begin
    if (list_end) begin
      cursor_next = 32'd0;
    end else if (done) begin
      cursor_next = pos;
    end else begin
      cursor_next = cursor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= rlp_pkg::PH_IDLE;
      accum  <= 32'd0;
      cursor <= 32'd0;
    end else if (step) begin
      phase  <= phase_next;
      accum  <= accum_next;
      cursor <= cursor_next;
    end
  end

  assign dec.done         = done;
  assign dec.list_end     = list_end;
  assign dec.out_of_range = done && (pos_plus >= 33'(MEM_HALFWORDS));
  assign dec.pos          = pos;
  assign dec.pos_next     = pos_plus[31:0];

endmodule

`default_nettype wire
